>>> design/erq_pkg.sv
// shared types and codes for the echo request tracker
package erq_pkg;

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_REPLY = 2'd1,
        OP_CHECK = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_SENT    = 3'd0,
        ST_FULL    = 3'd1,
        ST_MATCHED = 3'd2,
        ST_NOMATCH = 3'd3,
        ST_EXPIRED = 3'd4,
        ST_NONE    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RPL_RD,
        S_RPL_CMP,
        S_CHK_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_FINISH
    } state_t;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    localparam int SEQ_W  = 16;
    localparam int TIME_W = 32;

    typedef struct packed {
        logic    capture;
        logic    mem_rd;
        logic    wr_append;
        logic    wr_shift;
        logic    idx_inc;
        logic    cnt_dec;
        logic    res_load;
        status_t res_status;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    full;
        logic    empty;
        logic    scan_end;
        logic    match;
        logic    expired;
    } ctrl_sts_t;

endpackage

>>> design/erq_ctrl.sv
// sequencer for send, reply search, timeout check and table compaction
module erq_ctrl import erq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      out_free,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = ST_NONE;
        s_tready       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (sts.op)
                    OP_SEND: begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = sts.full ? ST_FULL : ST_SENT;
                        cmd.wr_append  = !sts.full;
                        state_next     = S_FINISH;
                    end
                    OP_REPLY: begin
                        state_next = S_RPL_RD;
                    end
                    OP_CHECK: begin
                        if (sts.empty) begin
                            cmd.res_load = 1'b1;
                            state_next   = S_FINISH;
                        end else begin
                            cmd.mem_rd = 1'b1;
                            state_next = S_CHK_CMP;
                        end
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        state_next   = S_FINISH;
                    end
                endcase
            end
            S_RPL_RD: begin
                if (sts.scan_end) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOMATCH;
                    state_next     = S_FINISH;
                end else begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_RPL_CMP;
                end
            end
            S_RPL_CMP: begin
                cmd.idx_inc = 1'b1;
                if (sts.match) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_MATCHED;
                    state_next     = S_SHF_RD;
                end else begin
                    state_next = S_RPL_RD;
                end
            end
            S_CHK_CMP: begin
                cmd.res_load = 1'b1;
                if (sts.expired) begin
                    cmd.res_status = ST_EXPIRED;
                    cmd.idx_inc    = 1'b1;
                    state_next     = S_SHF_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SHF_RD: begin
                if (sts.scan_end) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                // newer entry moves down one place to close the gap
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SHF_RD;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/erq_datapath.sv
// entry table memory, counters, comparators and result registers
module erq_datapath import erq_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_cmd_t         cmd,
    input  logic [1:0]        in_opcode,
    input  logic [TIME_W-1:0] in_time_now,
    input  logic [SEQ_W-1:0]  in_reply_seq,
    input  logic [TIME_W-1:0] timeout_ticks,
    output ctrl_sts_t         sts,
    output logic [2:0]        res_status,
    output logic [SEQ_W-1:0]  res_seq,
    output logic [TIME_W-1:0] res_time
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENT_W = SEQ_W + TIME_W;

    logic [ENT_W-1:0] entry_mem [TABLE_DEPTH];

    logic [1:0]        op_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SEQ_W-1:0]  rseq_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic [SEQ_W-1:0]  seq_reg;
    logic [SEQ_W-1:0]  seq_next;
    logic [ENT_W-1:0]  rd_data_reg;
    logic [2:0]        res_status_reg;
    logic [SEQ_W-1:0]  res_seq_reg;
    logic [TIME_W-1:0] res_time_reg;

    logic [CNT_W-1:0]  idx_m1;
    logic [SEQ_W-1:0]  rd_seq;
    logic [TIME_W-1:0] rd_time;
    logic [TIME_W-1:0] elapsed;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic [SEQ_W-1:0]  sel_seq;
    logic [TIME_W-1:0] sel_time;

    assign seq_next = seq_reg + SEQ_W'(1);
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign rd_seq   = rd_data_reg[ENT_W-1:TIME_W];
    assign rd_time  = rd_data_reg[TIME_W-1:0];
    assign elapsed  = now_reg - rd_time;

    assign wr_en   = cmd.wr_append || cmd.wr_shift;
    assign wr_addr = cmd.wr_append ? cnt_reg[IDX_W-1:0] : idx_m1[IDX_W-1:0];
    assign wr_data = cmd.wr_append ? {seq_next, now_reg} : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= entry_mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.wr_append) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        idx_next = idx_reg;
        if (cmd.capture) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            seq_reg <= '0;
            idx_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (cmd.wr_append) begin
                seq_reg <= seq_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= in_opcode;
            now_reg  <= in_time_now;
            rseq_reg <= in_reply_seq;
        end
    end

    always_comb begin
        case (cmd.res_status)
            ST_SENT: begin
                sel_seq  = seq_next;
                sel_time = '0;
            end
            ST_MATCHED: begin
                sel_seq  = rseq_reg;
                sel_time = rd_time;
            end
            ST_EXPIRED: begin
                sel_seq  = rd_seq;
                sel_time = rd_time;
            end
            default: begin
                sel_seq  = '0;
                sel_time = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_seq_reg    <= sel_seq;
            res_time_reg   <= sel_time;
        end
    end

    assign sts.op       = opcode_t'(op_reg);
    assign sts.full     = (cnt_reg == CNT_W'(TABLE_DEPTH));
    assign sts.empty    = (cnt_reg == '0);
    assign sts.scan_end = (idx_reg == cnt_reg);
    assign sts.match    = (rd_seq == rseq_reg);
    assign sts.expired  = (elapsed > timeout_ticks);

    assign res_status = res_status_reg;
    assign res_seq    = res_seq_reg;
    assign res_time   = res_time_reg;

endmodule

>>> design/echo_request_tracker_core.sv
// top level of the echo request tracker: register port, output stage, control and datapath
//
//  channel   ports      direction  contents
//  request   s_*        in         opcode, time_now, reply_seq
//  result    m_*        out        status, seq_out, send_tick
//  config    p*         in/out     timeout_ticks at byte address 0
//
// send, no-op and check on an empty table go from dispatch to the result; reply
// compares each entry searched and, on a match, moves each newer entry down with
// a read and a write; check compares the oldest entry and, when it expires, moves
// the newer entries down the same way. the next request is taken in the cycle after
// the result loads, and the single-port entry table does one access a cycle. reset
// is synchronous and needs no clearing pass. a result waiting in the output register
// does not stop the next request being taken; only the final load waits for it.
module echo_request_tracker_core import erq_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // opcode[1:0], time_now[33:2], reply_seq[49:34], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[2:0], seq_out[18:3], send_tick[50:19], zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ctrl_cmd_t         cmd;
    ctrl_sts_t         sts;
    logic              out_free;
    logic [31:0]       timeout_reg;
    logic              m_tvalid_reg;
    logic [55:0]       m_tdata_reg;
    logic [2:0]        res_status;
    logic [SEQ_W-1:0]  res_seq;
    logic [TIME_W-1:0] res_time;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
            timeout_reg <= pwdata;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {5'd0, res_time, res_seq, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    erq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    erq_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_opcode     (s_tdata[1:0]),
        .in_time_now   (s_tdata[33:2]),
        .in_reply_seq  (s_tdata[49:34]),
        .timeout_ticks (timeout_reg),
        .sts           (sts),
        .res_status    (res_status),
        .res_seq       (res_seq),
        .res_time      (res_time)
    );

`ifndef NO_ASSERTIONS
    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in progress");

    a_load_into_free_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result loaded over an untaken result");

    a_append_reports_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_append |-> cmd.res_load && cmd.res_status == ST_SENT && !sts.full)
        else $error("table append without a sent result");

    a_no_append_and_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_append && cmd.wr_shift))
        else $error("two table writes in one cycle");
`endif

endmodule
